### rtl/byte_ring_fifo_core_assert.svh
// Assertion macros for the byte ring FIFO core.
// Needs signals named clock and reset in the including module.
`ifndef BYTE_RING_FIFO_CORE_ASSERT_SVH
`define BYTE_RING_FIFO_CORE_ASSERT_SVH

// check while out of reset
`define BRF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// check at every edge, reset included
`define BRF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/brf_pkg.sv
// Shared types and constants of the byte ring FIFO core.
// Used by brf_rsp_stage and byte_ring_fifo_core; depends on nothing.
`default_nettype none

package brf_pkg;

   localparam int DEPTH     = 256;
   localparam int CAP_W     = 9;
   localparam int CNT_W     = 7;
   localparam int MAX_PUSH  = 8;
   localparam int MAX_COUNT = 64;

   localparam logic [2:0] MODE_PUSH    = 3'd0;
   localparam logic [2:0] MODE_POP     = 3'd1;
   localparam logic [2:0] MODE_PEEK    = 3'd2;
   localparam logic [2:0] MODE_DISCARD = 3'd3;
   localparam logic [2:0] MODE_PURGE   = 3'd4;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [7:0]       data_byte;
      logic             status;
      logic [CNT_W-1:0] moved_count;
      logic             last;
      logic [CAP_W-1:0] used_space;
      logic [CAP_W-1:0] free_space;
   } rsp_word_type;

endpackage

`default_nettype wire

### rtl/brf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds until the next read enable. No dependencies.
`default_nettype none

module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/brf_rsp_stage.sv
// Result output register for the byte ring FIFO core.
// Holds one word until the receiver takes it; uses brf_pkg.
`default_nettype none

module brf_rsp_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load_valid,
   input  wire brf_pkg::rsp_word_type load_word,
   output logic                       load_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output brf_pkg::rsp_word_type      rsp_word
);

   import brf_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   assign load_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load_valid && load_ready) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         word_ff <= load_word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

`default_nettype wire

### rtl/byte_ring_fifo_core.sv
// Byte ring FIFO core: request decode, store sequencing and result assembly.
// Uses brf_pkg, brf_ram, brf_rsp_stage and byte_ring_fifo_core_assert.svh.
//
// Usage:
// - csr channel writes the capacity (0 acts as 1, above DEPTH acts as DEPTH)
//   and empties the FIFO; it is taken only while no request is in progress.
// - req channel takes one word per request: mode, up to eight push bytes and
//   a count. rsp channel returns one word per popped or peeked byte, or one
//   word for every other request; last marks the final word, which alone
//   carries moved_count. used_space and free_space show the state after the
//   whole request on every word.
// - Push of k bytes writes one byte per cycle in ST_PUSH and then loads its
//   result from ST_EMIT. Pop and peek read one byte per cycle from the
//   store's single read port while the output register can take bytes; each
//   byte passes the store's read register before it is loaded. Other
//   requests load their result from ST_EMIT.
// - One request is worked at a time; the next is taken once the last result
//   of the previous one sits in the output register.
// - Reset empties the FIFO and sets the capacity to 256. The store itself is
//   not cleared; no clearing pass runs.
// - A stalled receiver holds the output register; reads then stop, with the
//   next byte held in the store's read register.
`default_nettype none

module byte_ring_fifo_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [brf_pkg::CAP_W-1:0] csr_capacity,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [2:0]               req_mode,
   input  wire logic [63:0]              req_push_bytes,
   input  wire logic [brf_pkg::CNT_W-1:0] req_count,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [7:0]                    rsp_data_byte,
   output logic                          rsp_status,
   output logic [brf_pkg::CNT_W-1:0]     rsp_moved_count,
   output logic                          rsp_last,
   output logic [brf_pkg::CAP_W-1:0]     rsp_used_space,
   output logic [brf_pkg::CAP_W-1:0]     rsp_free_space
);

   import brf_pkg::*;

   `include "byte_ring_fifo_core_assert.svh"

   localparam int AW = $clog2(DEPTH);
   localparam int SW = ((AW > CAP_W) ? AW : CAP_W) + 1;

   state_type        state_ff, state_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CAP_W-1:0] used_ff, used_in;
   logic [AW-1:0]    wr_idx_ff, wr_idx_in;
   logic [AW-1:0]    rd_idx_ff, rd_idx_in;
   logic [AW-1:0]    walk_ff, walk_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic [63:0]      shift_ff, shift_in;
   logic             pend_status_ff, pend_status_in;
   logic [CNT_W-1:0] pend_moved_ff, pend_moved_in;
   logic             rd_valid_ff, rd_valid_in;
   logic             rd_last_ff, rd_last_in;

   logic [CAP_W-1:0] free_now;
   logic             is_empty;
   logic             is_full;
   logic [CNT_W-1:0] cnt_sat;
   logic [CNT_W-1:0] take_n;
   logic [SW-1:0]    rd_sum;
   logic [AW-1:0]    rd_adv;
   logic [SW-1:0]    wr_inc;
   logic [AW-1:0]    wr_next;
   logic [SW-1:0]    walk_inc;
   logic [AW-1:0]    walk_next;
   logic [CAP_W-1:0] cap_eff;

   logic             ram_we;
   logic             ram_re;
   logic [7:0]       ram_q;

   logic             out_load;
   logic             out_ready;
   logic             move;
   rsp_word_type     out_word;
   rsp_word_type     rsp_word;

   brf_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wr_idx_ff),
      .wr_data(shift_ff[7:0]),
      .rd_en  (ram_re),
      .rd_addr(walk_ff),
      .rd_data(ram_q)
   );

   brf_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load_valid(out_load),
      .load_word (out_word),
      .load_ready(out_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_data_byte   = rsp_word.data_byte;
   assign rsp_status      = rsp_word.status;
   assign rsp_moved_count = rsp_word.moved_count;
   assign rsp_last        = rsp_word.last;
   assign rsp_used_space  = rsp_word.used_space;
   assign rsp_free_space  = rsp_word.free_space;

   always_comb begin
      free_now = cap_ff - used_ff;
      is_empty = (used_ff == '0);
      is_full  = (used_ff == cap_ff);
      cnt_sat  = (req_count > CNT_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT) : req_count;
      take_n   = (CAP_W'(cnt_sat) < used_ff) ? cnt_sat : used_ff[CNT_W-1:0];

      rd_sum   = SW'(rd_idx_ff) + SW'(take_n);
      rd_adv   = (rd_sum >= SW'(cap_ff)) ? AW'(rd_sum - SW'(cap_ff)) : AW'(rd_sum);
      wr_inc   = SW'(wr_idx_ff) + SW'(1);
      wr_next  = (wr_inc >= SW'(cap_ff)) ? '0 : AW'(wr_inc);
      walk_inc = SW'(walk_ff) + SW'(1);
      walk_next = (walk_inc >= SW'(cap_ff)) ? '0 : AW'(walk_inc);

      if (csr_capacity == '0) begin
         cap_eff = CAP_W'(1);
      end else if (int'(csr_capacity) > DEPTH) begin
         cap_eff = CAP_W'(DEPTH);
      end else begin
         cap_eff = csr_capacity;
      end
   end

   assign move = rd_valid_ff && out_ready;

   always_comb begin
      state_in       = state_ff;
      cap_in         = cap_ff;
      used_in        = used_ff;
      wr_idx_in      = wr_idx_ff;
      rd_idx_in      = rd_idx_ff;
      walk_in        = walk_ff;
      remain_in      = remain_ff;
      shift_in       = shift_ff;
      pend_status_in = pend_status_ff;
      pend_moved_in  = pend_moved_ff;
      rd_valid_in    = rd_valid_ff;
      rd_last_in     = rd_last_ff;
      csr_ready      = 1'b0;
      req_ready      = 1'b0;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      out_load       = 1'b0;

      out_word.data_byte   = 8'd0;
      out_word.status      = pend_status_ff;
      out_word.moved_count = pend_moved_ff;
      out_word.last        = 1'b1;
      out_word.used_space  = used_ff;
      out_word.free_space  = free_now;

      unique case (state_ff)
         ST_IDLE: begin
            csr_ready = 1'b1;
            req_ready = !csr_valid;
            if (csr_valid) begin
               cap_in    = cap_eff;
               used_in   = '0;
               wr_idx_in = '0;
               rd_idx_in = '0;
            end else if (req_valid) begin
               pend_status_in = STATUS_OK;
               pend_moved_in  = '0;
               state_in       = ST_EMIT;
               unique case (req_mode)
                  MODE_PUSH: begin
                     if (is_full || req_count > CNT_W'(MAX_PUSH)
                         || CAP_W'(req_count) > free_now) begin
                        pend_status_in = STATUS_REFUSED;
                     end else if (req_count != '0) begin
                        used_in       = used_ff + CAP_W'(req_count);
                        shift_in      = req_push_bytes;
                        remain_in     = req_count;
                        pend_moved_in = req_count;
                        state_in      = ST_PUSH;
                     end
                  end
                  MODE_POP, MODE_PEEK: begin
                     if (is_empty) begin
                        pend_status_in = STATUS_REFUSED;
                     end else if (cnt_sat != '0) begin
                        remain_in     = take_n;
                        walk_in       = rd_idx_ff;
                        pend_moved_in = take_n;
                        state_in      = ST_READ;
                        if (req_mode == MODE_POP) begin
                           used_in   = used_ff - CAP_W'(take_n);
                           rd_idx_in = rd_adv;
                        end
                     end
                  end
                  MODE_DISCARD: begin
                     if (!is_empty && cnt_sat != '0) begin
                        used_in       = used_ff - CAP_W'(take_n);
                        rd_idx_in     = rd_adv;
                        pend_moved_in = take_n;
                     end
                  end
                  MODE_PURGE: begin
                     used_in   = '0;
                     wr_idx_in = '0;
                     rd_idx_in = '0;
                  end
                  default: begin
                     pend_status_in = STATUS_REFUSED;
                  end
               endcase
            end
         end
         ST_PUSH: begin
            ram_we    = 1'b1;
            wr_idx_in = wr_next;
            shift_in  = shift_ff >> 8;
            remain_in = remain_ff - CNT_W'(1);
            if (remain_ff == CNT_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_READ: begin
            if (remain_ff != '0 && (!rd_valid_ff || move)) begin
               ram_re      = 1'b1;
               walk_in     = walk_next;
               remain_in   = remain_ff - CNT_W'(1);
               rd_valid_in = 1'b1;
               rd_last_in  = (remain_ff == CNT_W'(1));
            end else if (move) begin
               rd_valid_in = 1'b0;
            end
            if (move) begin
               out_load             = 1'b1;
               out_word.data_byte   = ram_q;
               out_word.status      = STATUS_OK;
               out_word.moved_count = rd_last_ff ? pend_moved_ff : '0;
               out_word.last        = rd_last_ff;
               if (rd_last_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (out_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cap_ff      <= CAP_W'(256);
         used_ff     <= '0;
         wr_idx_ff   <= '0;
         rd_idx_ff   <= '0;
         remain_ff   <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cap_ff      <= cap_in;
         used_ff     <= used_in;
         wr_idx_ff   <= wr_idx_in;
         rd_idx_ff   <= rd_idx_in;
         remain_ff   <= remain_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff        <= walk_in;
      shift_ff       <= shift_in;
      pend_status_ff <= pend_status_in;
      pend_moved_ff  <= pend_moved_in;
      rd_last_ff     <= rd_last_in;
   end

   `BRF_ASSERT_ALWAYS(a_reset_empties,
      reset |=> (state_ff == ST_IDLE && used_ff == '0 && !rd_valid_ff),
      "reset did not empty the FIFO")
   `BRF_ASSERT(a_used_within_cap, used_ff <= cap_ff,
      "fill level above capacity")
   `BRF_ASSERT(a_cap_nonzero, cap_ff != '0,
      "capacity register is zero")
   `BRF_ASSERT(a_idle_drained,
      (state_ff == ST_IDLE) |-> (remain_ff == '0 && !rd_valid_ff),
      "idle with bytes still in flight")
   `BRF_ASSERT(a_push_index_in_range,
      (state_ff == ST_PUSH) |-> (SW'(wr_idx_ff) < SW'(cap_ff)),
      "write index beyond capacity during push")

endmodule

`default_nettype wire
